FILE: hw/rtl/osfp_pkg.sv
// Shared types and constants for the obstacle / start-time frame parser.
// No dependencies; used by every module of the block.
package osfp_pkg;

    // Frame delimiters
    localparam logic [7:0] START_OBSTACLE = 8'h21;  // '!'
    localparam logic [7:0] START_TIME     = 8'h3F;  // '?'
    localparam logic [7:0] TERMINATOR     = 8'h0A;  // newline

    // Position of the terminator byte in each frame kind
    localparam logic [2:0] LAST_POS_OBSTACLE = 3'd6;
    localparam logic [2:0] LAST_POS_TIME     = 3'd3;
    localparam logic [2:0] POS_IDLE          = 3'd0;
    localparam logic [2:0] POS_FIRST         = 3'd1;

    localparam int STORE_DEPTH = 5;

    // Frame kinds as reported on the result channel
    localparam logic KIND_OBSTACLE = 1'b0;
    localparam logic KIND_TIME     = 1'b1;

    // Configuration port
    localparam int                     CFG_IDX_W           = 2;
    localparam logic [CFG_IDX_W-1:0]   CFG_OWN_START_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]   CFG_MISMATCH_MARGIN = 2'd1;
    localparam logic [15:0]            OWN_TIME_RESET      = 16'd0;
    localparam logic [15:0]            MARGIN_RESET        = 16'd300;

    // Byte moving from the input register into the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_item;

    // One parsed result
    typedef struct packed {
        logic        frame_kind;
        logic [7:0]  obstacle_id;
        logic [15:0] obstacle_x;
        logic [15:0] obstacle_y;
        logic [15:0] received_time;
        logic        time_mismatch;
    } t_result;

endpackage

FILE: hw/rtl/osfp_in_stage.sv
// Input register of the frame parser: holds one received byte.
// Depends on osfp_pkg.
module osfp_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_advance,   // downstream takes the held byte
    output osfp_pkg::t_item       o_item
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

endmodule

FILE: hw/rtl/osfp_parse.sv
// Frame tracking, payload store and result decode for the frame parser.
// Depends on osfp_pkg.
module osfp_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,       // held byte is consumed this cycle
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_own_time,
    input  logic [15:0]           i_margin,
    output logic                  o_res_valid,
    output osfp_pkg::t_result     o_res
);

    logic [2:0] r_pos;
    logic       r_is_time;
    logic [7:0] r_store [osfp_pkg::STORE_DEPTH];

    logic [2:0]  n_pos;
    logic        n_is_time;
    logic        last_byte;
    logic        store_we;
    logic [2:0]  store_idx;
    logic [15:0] rx_time;
    logic [16:0] diff;

    assign last_byte = r_is_time ? (r_pos == osfp_pkg::LAST_POS_TIME)
                                 : (r_pos == osfp_pkg::LAST_POS_OBSTACLE);
    assign store_we  = i_fire && (r_pos != osfp_pkg::POS_IDLE) && !last_byte;
    assign store_idx = r_pos - 3'd1;

    always_comb begin
        n_pos     = r_pos;
        n_is_time = r_is_time;
        if (r_pos == osfp_pkg::POS_IDLE) begin
            if (i_rx_byte == osfp_pkg::START_OBSTACLE) begin
                n_pos     = osfp_pkg::POS_FIRST;
                n_is_time = 1'b0;
            end else if (i_rx_byte == osfp_pkg::START_TIME) begin
                n_pos     = osfp_pkg::POS_FIRST;
                n_is_time = 1'b1;
            end
        end else if (last_byte) begin
            n_pos = osfp_pkg::POS_IDLE;
        end else begin
            n_pos = r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= osfp_pkg::POS_IDLE;
            r_is_time <= 1'b0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_is_time <= n_is_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= i_rx_byte;
        end
    end

    // Result decode: own - received as a 17-bit two's complement difference
    assign rx_time = {r_store[1], r_store[0]};
    assign diff    = {1'b0, i_own_time} - {1'b0, rx_time};

    assign o_res_valid = i_fire && (r_pos != osfp_pkg::POS_IDLE) && last_byte
                         && (i_rx_byte == osfp_pkg::TERMINATOR);

    always_comb begin
        o_res = '0;
        if (r_is_time) begin
            o_res.frame_kind    = osfp_pkg::KIND_TIME;
            o_res.received_time = rx_time;
            o_res.time_mismatch = !diff[16] && (diff[15:0] > i_margin);
        end else begin
            o_res.frame_kind  = osfp_pkg::KIND_OBSTACLE;
            o_res.obstacle_id = r_store[0];
            o_res.obstacle_x  = {r_store[2], r_store[1]};
            o_res.obstacle_y  = {r_store[4], r_store[3]};
        end
    end

endmodule

FILE: hw/rtl/osfp_out_stage.sv
// Result register of the frame parser: holds one result until taken.
// Depends on osfp_pkg.
module osfp_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,       // parser consumes a byte this cycle
    input  logic                  i_res_valid,
    input  osfp_pkg::t_result     i_res,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic                  o_free,       // can take a new result this cycle
    output osfp_pkg::t_result     o_res
);

    logic              r_valid;
    osfp_pkg::t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/obstacle_and_start_time_frame_parser_core.sv
// Top level of the obstacle / start-time serial frame parser.
// Depends on osfp_pkg, osfp_in_stage, osfp_parse, osfp_out_stage.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_rx_byte): one received serial
//   byte per transaction. '!' opens a 7-byte obstacle frame, '?' a 4-byte
//   start-time frame; other bytes between frames are ignored. The last byte
//   of a frame must be a newline, else the frame is dropped with no result.
//   Output channel (o_out_valid / i_out_ready / result fields): one result per
//   good frame. Fields that do not belong to the frame kind read as zero.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 own start time, index 1 mismatch margin; other indexes ignored.
//   Always ready; write only while no frame result is pending.
// Path: a terminating byte goes into the input register, then its result is
//   loaded into the result register and shown from there.
// Throughput: one byte per cycle when not stalled; the parser is a single
//   combinational pass between the input register and the result register.
// Reset (synchronous, active low): parser back to idle, both stages empty,
//   own start time 0, margin 300.
// Receiver stall: the result register holds; the input register still takes
//   one more byte, then o_in_ready drops until the result is taken.
module obstacle_and_start_time_frame_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_rx_byte,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_frame_kind,
    output logic [7:0]                     o_obstacle_id,
    output logic [15:0]                    o_obstacle_x,
    output logic [15:0]                    o_obstacle_y,
    output logic [15:0]                    o_received_time,
    output logic                           o_time_mismatch,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [osfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    // Config registers
    logic [15:0] r_own_time;
    logic [15:0] r_margin;

    osfp_pkg::t_item   item;
    osfp_pkg::t_result parse_res;
    osfp_pkg::t_result out_res;
    logic              parse_valid;
    logic              out_free;
    logic              fire;          // held byte moves through the parser

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_time <= osfp_pkg::OWN_TIME_RESET;
            r_margin   <= osfp_pkg::MARGIN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == osfp_pkg::CFG_OWN_START_TIME) begin
                r_own_time <= i_cfg_data;
            end else if (i_cfg_index == osfp_pkg::CFG_MISMATCH_MARGIN) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    // A byte may advance whenever the result slot is empty or draining,
    // whether or not it completes a frame.
    assign fire = item.valid && out_free;

    osfp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_rx_byte (i_rx_byte),
        .i_advance (fire),
        .o_item    (item)
    );

    osfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_rx_byte   (item.rx_byte),
        .i_own_time  (r_own_time),
        .i_margin    (r_margin),
        .o_res_valid (parse_valid),
        .o_res       (parse_res)
    );

    osfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res_valid (parse_valid),
        .i_res       (parse_res),
        .i_ready     (i_out_ready),
        .o_valid     (o_out_valid),
        .o_free      (out_free),
        .o_res       (out_res)
    );

    assign o_frame_kind    = out_res.frame_kind;
    assign o_obstacle_id   = out_res.obstacle_id;
    assign o_obstacle_x    = out_res.obstacle_x;
    assign o_obstacle_y    = out_res.obstacle_y;
    assign o_received_time = out_res.received_time;
    assign o_time_mismatch = out_res.time_mismatch;

endmodule

FILE: hw/rtl/osfp_checker.sv
// Port-level checks for the frame parser top level, attached by bind.
// Depends on osfp_pkg and obstacle_and_start_time_frame_parser_core.
module osfp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic                           o_frame_kind,
    input  logic [7:0]                     o_obstacle_id,
    input  logic [15:0]                    o_obstacle_x,
    input  logic [15:0]                    o_obstacle_y,
    input  logic [15:0]                    o_received_time,
    input  logic                           o_time_mismatch
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result payload stays put
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_frame_kind) && $stable(o_obstacle_id) && $stable(o_obstacle_x)
            && $stable(o_obstacle_y) && $stable(o_received_time)
            && $stable(o_time_mismatch))
        else $error("result payload changed while stalled");

    // Fields of the other frame kind read as zero
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_frame_kind == osfp_pkg::KIND_TIME)
                ? (o_obstacle_id == 8'd0 && o_obstacle_x == 16'd0
                   && o_obstacle_y == 16'd0)
                : (o_received_time == 16'd0 && !o_time_mismatch))
        else $error("foreign frame fields not zero");

endmodule

bind obstacle_and_start_time_frame_parser_core osfp_checker u_osfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_frame_kind    (o_frame_kind),
    .o_obstacle_id   (o_obstacle_id),
    .o_obstacle_x    (o_obstacle_x),
    .o_obstacle_y    (o_obstacle_y),
    .o_received_time (o_received_time),
    .o_time_mismatch (o_time_mismatch)
);
